@@ src/usb_ctl_pkg.sv @@
// ----------------------------------------------------------------------------
// USB control endpoint package
// Shared codes, constants and widths for the control endpoint request handler.
// ----------------------------------------------------------------------------
package usb_ctl_pkg;

	localparam int unsigned CHUNK_BYTES = 80;
	localparam int unsigned STRING_COUNT = 2;

	localparam logic [6:0] ADDR_MASK = 7'h7f;
	localparam logic [15:0] DEVICE_DESC_BYTES = 16'd18;
	localparam logic [15:0] LANGUAGE_DESC_BYTES = 16'd4;
	localparam logic [15:0] CHUNK_LEN = 16'(CHUNK_BYTES);

	typedef enum logic [1:0] {
		MODE_SETUP = 2'd0,
		MODE_IN_DONE = 2'd1,
		MODE_BUS_RESET = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_STALL = 2'd1,
		ACT_SEND = 2'd2,
		ACT_ENABLE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		SRC_SCRATCH = 3'd0,
		SRC_DEVICE = 3'd1,
		SRC_CONFIG = 3'd2,
		SRC_LANGUAGE = 3'd3,
		SRC_MANUFACTURER = 3'd4,
		SRC_PRODUCT = 3'd5
	} source_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_ENABLED = 2'd1,
		EV_DISABLED = 2'd2
	} cfg_event_t;

	localparam logic [1:0] KIND_STANDARD = 2'd0;

	localparam logic [7:0] REQ_GET_STATUS = 8'd0;
	localparam logic [7:0] REQ_CLEAR_FEATURE = 8'd1;
	localparam logic [7:0] REQ_SET_FEATURE = 8'd3;
	localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE = 8'd10;

	localparam logic [7:0] DESC_DEVICE = 8'd1;
	localparam logic [7:0] DESC_CONFIG = 8'd2;
	localparam logic [7:0] DESC_STRING = 8'd3;

	localparam logic [1:0] REG_CONFIG_TOTAL_LENGTH = 2'd0;
	localparam logic [1:0] REG_CONFIG_NUMBER = 2'd1;
	localparam logic [1:0] REG_MANUFACTURER_BYTES = 2'd2;
	localparam logic [1:0] REG_PRODUCT_BYTES = 2'd3;

endpackage

@@ src/usb_control_endpoint_request_handler_unit.sv @@
// ----------------------------------------------------------------------------
// USB control endpoint request handler
// Decodes setup, IN-complete and bus reset events of endpoint zero and
// returns one action per event, sending descriptors in fixed-size chunks.
// ----------------------------------------------------------------------------
// An accepted event passes through one input register and one result
// register, with the decode between them. Throughput is one event per
// cycle while the output is not stalled; the endpoint state is updated in the
// same cycle that the result register loads, so events may follow directly.
// Reset clears the endpoint state, the pipeline valids and sets the
// configuration registers to their defaults.
module usb_control_endpoint_request_handler_unit
	import usb_ctl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  mode,
	input  logic [1:0]  request_kind,
	input  logic [7:0]  request_code,
	input  logic [15:0] request_value,
	input  logic [15:0] length_requested,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  action,
	output logic [2:0]  source,
	output logic [15:0] byte_offset,
	output logic [6:0]  packet_bytes,
	output logic        auto_zero_packet,
	output logic [7:0]  scratch_byte,
	output logic [1:0]  configuration_event,
	output logic [6:0]  address_out
);

	logic [15:0] config_total_length_q;
	logic [7:0]  config_number_q;
	logic [7:0]  manufacturer_bytes_q;
	logic [7:0]  product_bytes_q;

	logic [7:0]  current_configuration_q;
	logic [6:0]  device_address_q;
	logic        address_enabled_q;
	source_t     pending_source_q;
	logic [15:0] pending_offset_q;
	logic [15:0] bytes_remaining_q;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  code_s1;
	logic [15:0] value_s1;
	logic [15:0] wlen_s1;

	logic        out_free;
	logic        advance;

	action_t     act_d;
	source_t     src_d;
	logic [15:0] off_d;
	logic [6:0]  len_d;
	logic        zlp_d;
	logic [7:0]  scratch_d;
	cfg_event_t  ev_d;

	logic [7:0]  cur_cfg_n;
	logic [6:0]  addr_n;
	logic        addr_en_n;
	source_t     psrc_n;
	logic [15:0] poff_n;
	logic [15:0] prem_n;

	logic [15:0] desc_len;
	source_t     desc_src;
	logic [7:0]  desc_type;
	logic [7:0]  desc_index;
	logic [15:0] xfer_len;

	logic [15:0] chunk_rem;
	source_t     chunk_src;
	logic [15:0] chunk_off;
	logic [15:0] chunk_size;
	logic [15:0] chunk_left;

	assign out_free = !result_valid || !result_stall;
	assign advance = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	assign desc_type = value_s1[15:8];
	assign desc_index = value_s1[7:0];

	always_comb begin
		desc_len = '0;
		desc_src = SRC_SCRATCH;
		if (desc_type == DESC_DEVICE) begin
			desc_len = DEVICE_DESC_BYTES;
			desc_src = SRC_DEVICE;
		end else if (desc_type == DESC_CONFIG) begin
			desc_len = config_total_length_q;
			desc_src = SRC_CONFIG;
		end else if (desc_type == DESC_STRING) begin
			if (desc_index == 8'd0) begin
				desc_len = LANGUAGE_DESC_BYTES;
				desc_src = SRC_LANGUAGE;
			end else if (desc_index > 8'(STRING_COUNT) || desc_index > 8'd2) begin
				desc_len = '0;
			end else if (desc_index == 8'd1) begin
				desc_len = {8'd0, manufacturer_bytes_q};
				desc_src = SRC_MANUFACTURER;
			end else begin
				desc_len = {8'd0, product_bytes_q};
				desc_src = SRC_PRODUCT;
			end
		end
		xfer_len = (desc_len > wlen_s1) ? wlen_s1 : desc_len;
	end

	// The chunk path serves both a new descriptor and a continued transfer.
	always_comb begin
		if (mode_s1 == MODE_SETUP) begin
			chunk_rem = xfer_len;
			chunk_src = desc_src;
			chunk_off = '0;
		end else begin
			chunk_rem = bytes_remaining_q;
			chunk_src = pending_source_q;
			chunk_off = pending_offset_q;
		end
		chunk_size = (chunk_rem > CHUNK_LEN) ? CHUNK_LEN : chunk_rem;
		chunk_left = chunk_rem - chunk_size;
	end

	always_comb begin
		act_d = ACT_NONE;
		src_d = SRC_SCRATCH;
		off_d = '0;
		len_d = '0;
		zlp_d = 1'b0;
		scratch_d = '0;
		ev_d = EV_NONE;
		cur_cfg_n = current_configuration_q;
		addr_n = device_address_q;
		addr_en_n = address_enabled_q;
		psrc_n = pending_source_q;
		poff_n = pending_offset_q;
		prem_n = bytes_remaining_q;

		unique case (mode_t'(mode_s1))
			MODE_SETUP: begin
				psrc_n = SRC_SCRATCH;
				poff_n = '0;
				prem_n = '0;
				if (kind_s1 == KIND_STANDARD) begin
					act_d = ACT_SEND;
					zlp_d = 1'b1;
					unique case (code_s1)
						REQ_GET_STATUS: len_d = 7'd2;
						REQ_CLEAR_FEATURE, REQ_SET_FEATURE: len_d = '0;
						REQ_SET_ADDRESS: begin
							addr_n = value_s1[6:0] & ADDR_MASK;
							addr_en_n = 1'b0;
						end
						REQ_GET_DESCRIPTOR: begin
							if (desc_len == 16'd0) begin
								act_d = ACT_STALL;
								zlp_d = 1'b0;
							end else if (xfer_len == 16'd0) begin
								src_d = desc_src;
							end else begin
								src_d = chunk_src;
								off_d = chunk_off;
								len_d = chunk_size[6:0];
								zlp_d = (chunk_left == 16'd0);
								if (chunk_left != 16'd0) begin
									psrc_n = chunk_src;
									poff_n = chunk_off + chunk_size;
									prem_n = chunk_left;
								end
							end
						end
						REQ_GET_CONFIGURATION: begin
							len_d = 7'd1;
							scratch_d = current_configuration_q;
						end
						REQ_SET_CONFIGURATION: begin
							if (value_s1 == 16'd0 && current_configuration_q != 8'd0) begin
								cur_cfg_n = '0;
								ev_d = EV_DISABLED;
							end else if (value_s1 == {8'd0, config_number_q} &&
								current_configuration_q != config_number_q) begin
								cur_cfg_n = config_number_q;
								ev_d = EV_ENABLED;
							end else begin
								act_d = ACT_STALL;
								zlp_d = 1'b0;
							end
						end
						REQ_GET_INTERFACE: begin
							if (current_configuration_q == 8'd0) begin
								act_d = ACT_STALL;
								zlp_d = 1'b0;
							end else begin
								len_d = 7'd1;
							end
						end
						default: begin
							act_d = ACT_STALL;
							zlp_d = 1'b0;
						end
					endcase
				end
			end
			MODE_IN_DONE: begin
				if (device_address_q != 7'd0 && !address_enabled_q) begin
					addr_en_n = 1'b1;
					act_d = ACT_ENABLE;
				end else if (bytes_remaining_q != 16'd0) begin
					act_d = ACT_SEND;
					src_d = chunk_src;
					off_d = chunk_off;
					len_d = chunk_size[6:0];
					zlp_d = (chunk_left == 16'd0);
					prem_n = chunk_left;
					if (chunk_left == 16'd0) begin
						psrc_n = SRC_SCRATCH;
						poff_n = '0;
					end else begin
						poff_n = chunk_off + chunk_size;
					end
				end
			end
			MODE_BUS_RESET: begin
				addr_n = '0;
				addr_en_n = 1'b0;
			end
			MODE_UNUSED: begin
				act_d = ACT_NONE;
			end
			default: begin
				act_d = ACT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			config_total_length_q <= '0;
			config_number_q <= 8'd1;
			manufacturer_bytes_q <= 8'd2;
			product_bytes_q <= 8'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONFIG_TOTAL_LENGTH: config_total_length_q <= cfg_data;
				REG_CONFIG_NUMBER: config_number_q <= cfg_data[7:0];
				REG_MANUFACTURER_BYTES: manufacturer_bytes_q <= cfg_data[7:0];
				REG_PRODUCT_BYTES: product_bytes_q <= cfg_data[7:0];
				default: config_number_q <= config_number_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			mode_s1 <= mode;
			kind_s1 <= request_kind;
			code_s1 <= request_code;
			value_s1 <= request_value;
			wlen_s1 <= length_requested;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_configuration_q <= '0;
			device_address_q <= '0;
			address_enabled_q <= 1'b0;
			pending_source_q <= SRC_SCRATCH;
			pending_offset_q <= '0;
			bytes_remaining_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (out_free) begin
				result_valid <= valid_s1;
			end
			if (advance) begin
				current_configuration_q <= cur_cfg_n;
				device_address_q <= addr_n;
				address_enabled_q <= addr_en_n;
				pending_source_q <= psrc_n;
				pending_offset_q <= poff_n;
				bytes_remaining_q <= prem_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action <= act_d;
			source <= src_d;
			byte_offset <= off_d;
			packet_bytes <= len_d;
			auto_zero_packet <= zlp_d;
			scratch_byte <= scratch_d;
			configuration_event <= ev_d;
			address_out <= addr_n;
		end
	end

endmodule
